// ===== src/cgwm_pkg.sv =====
// Shared types and constants for the coverage grid window marker.
// Used by the controller, the datapath and the top level; depends on nothing.
package cgwm_pkg;

	localparam int MAX_WIDTH  = 64;
	localparam int MAX_HEIGHT = 64;
	localparam int MAX_RANGE  = 15;

	localparam int POS_W   = 6;
	localparam int CODE_W  = 8;
	localparam int RANGE_W = 4;
	localparam int SIZE_W  = 7;
	localparam int COORD_W = 7;
	localparam int CFG_W   = 7;
	localparam int CIDX_W  = 2;
	localparam int ADDR_W  = $clog2(MAX_WIDTH) + $clog2(MAX_HEIGHT);
	localparam int DEPTH   = 1 << ADDR_W;

	localparam logic [CODE_W-1:0]  CODE_UNSCANNED = '0;
	localparam logic [CODE_W-1:0]  CODE_SCANNED   = 8'd2;

	localparam logic [CIDX_W-1:0] CFG_RANGE  = 2'd0;
	localparam logic [CIDX_W-1:0] CFG_WIDTH  = 2'd1;
	localparam logic [CIDX_W-1:0] CFG_HEIGHT = 2'd2;

	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_MARK  = 2'd1,
		OP_FIND  = 2'd2
	} opcode_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SETUP,
		ST_WRITE,
		ST_SCAN,
		ST_DRAIN,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic load;
		logic setup;
		logic issue;
		logic wr_tile;
		logic set_found;
		logic set_all;
		logic clear;
	} cgwm_cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       clr_last;
		logic       empty;
		logic       last;
		logic       hit;
	} cgwm_stat_t;

endpackage

// ===== src/cgwm_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module cgwm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== src/cgwm_ctrl.sv =====
// Controller state machine of the coverage grid window marker.
// Depends on cgwm_pkg; drives the datapath by command beats and reads its status.
module cgwm_ctrl
	import cgwm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  cgwm_stat_t stat,
	output cgwm_cmd_t  cmd,
	output logic       busy,
	output logic       done
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clear = 1'b1;
				if (stat.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_SETUP;
				end
			end
			ST_SETUP: begin
				cmd.setup = 1'b1;
				case (stat.op)
					OP_WRITE: state_d = ST_WRITE;
					OP_MARK,
					OP_FIND:  state_d = ST_SCAN;
					default:  state_d = ST_RESP;
				endcase
			end
			ST_WRITE: begin
				cmd.wr_tile = 1'b1;
				state_d     = ST_RESP;
			end
			ST_SCAN: begin
				if (stat.empty) begin
					cmd.set_all = (stat.op == OP_FIND);
					state_d     = ST_RESP;
				end else if (stat.op == OP_FIND && stat.hit) begin
					cmd.set_found = 1'b1;
					state_d       = ST_RESP;
				end else begin
					cmd.issue = 1'b1;
					if (stat.last) begin
						state_d = ST_DRAIN;
					end
				end
			end
			ST_DRAIN: begin
				// The final read returns here; a miss on it means the grid is fully scanned.
				if (stat.op == OP_FIND) begin
					cmd.set_found = stat.hit;
					cmd.set_all   = !stat.hit;
				end
				state_d = ST_RESP;
			end
			ST_RESP: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);
	assign done = (state_q == ST_RESP);

`ifndef SYNTHESIS
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result strobe lasted more than one cycle");
	a_done_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy) else $error("block not idle after a result");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !done)) else $error("accepted command did not start");
	a_found_xor_all: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.set_found && cmd.set_all)) else $error("found and all-scanned set together");
`endif

endmodule

// ===== src/cgwm_dp.sv =====
// Datapath of the coverage grid window marker: configuration, command and bound
// registers, the cell scanner, the grid memory and the result registers. Uses cgwm_pkg, cgwm_ram.
module cgwm_dp
	import cgwm_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [CIDX_W-1:0]         cfg_index,
	input  logic [CFG_W-1:0]          cfg_data,
	input  logic [1:0]                opcode,
	input  logic [POS_W-1:0]          pos_x,
	input  logic [POS_W-1:0]          pos_y,
	input  logic [CODE_W-1:0]         tile_code,
	input  cgwm_cmd_t                 cmd,
	output cgwm_stat_t                stat,
	output logic                      found,
	output logic signed [COORD_W-1:0] tile_x,
	output logic signed [COORD_W-1:0] tile_y,
	output logic                      all_scanned
);

	logic [RANGE_W-1:0] scan_range_q;
	logic [SIZE_W-1:0]  grid_width_q, grid_height_q;
	logic [1:0]         op_q;
	logic [POS_W-1:0]   px_q, py_q;
	logic [CODE_W-1:0]  code_q;

	logic [POS_W-1:0] xlo_q, xhi_q, yhi_q;
	logic             empty_q;
	logic [POS_W-1:0] x_q, y_q, x_s1, y_s1;
	logic             rd_valid_s1;
	logic [ADDR_W-1:0] clr_q;

	logic [RANGE_W-1:0] rng;
	logic [SIZE_W-1:0]  w_use, h_use;
	logic signed [8:0]  r_s, px_s, py_s, wm1, hm1;
	logic signed [8:0]  xa, xb, ya, yb;
	logic signed [8:0]  xlo_c, xhi_c, ylo_c, yhi_c;

	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic [CODE_W-1:0] mem_wdata, mem_rdata;
	logic              hit, mark_hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_range_q  <= 4'd2;
			grid_width_q  <= 7'd64;
			grid_height_q <= 7'd64;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_RANGE:  scan_range_q  <= cfg_data[RANGE_W-1:0];
				CFG_WIDTH:  grid_width_q  <= cfg_data[SIZE_W-1:0];
				CFG_HEIGHT: grid_height_q <= cfg_data[SIZE_W-1:0];
				default:    ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= opcode;
			px_q   <= pos_x;
			py_q   <= pos_y;
			code_q <= tile_code;
		end
	end

	// Window bounds, clipped to rows and columns 1..size-1; the search spans the whole grid.
	always_comb begin
		rng   = (scan_range_q > RANGE_W'(MAX_RANGE)) ? RANGE_W'(MAX_RANGE) : scan_range_q;
		w_use = (grid_width_q > SIZE_W'(MAX_WIDTH)) ? SIZE_W'(MAX_WIDTH) : grid_width_q;
		h_use = (grid_height_q > SIZE_W'(MAX_HEIGHT)) ? SIZE_W'(MAX_HEIGHT) : grid_height_q;
		r_s   = $signed({5'b0, rng});
		px_s  = $signed({3'b0, px_q});
		py_s  = $signed({3'b0, py_q});
		wm1   = $signed({2'b0, w_use}) - 9'sd1;
		hm1   = $signed({2'b0, h_use}) - 9'sd1;
		xa    = px_s - r_s;
		xb    = px_s + r_s;
		ya    = py_s - r_s;
		yb    = py_s + r_s;
		if (op_q == OP_MARK) begin
			xlo_c = (xa < 9'sd1) ? 9'sd1 : xa;
			xhi_c = (xb > wm1) ? wm1 : xb;
			ylo_c = (ya < 9'sd1) ? 9'sd1 : ya;
			yhi_c = (yb > hm1) ? hm1 : yb;
		end else begin
			xlo_c = 9'sd0;
			xhi_c = wm1;
			ylo_c = 9'sd0;
			yhi_c = hm1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.setup) begin
			xlo_q   <= xlo_c[POS_W-1:0];
			xhi_q   <= xhi_c[POS_W-1:0];
			yhi_q   <= yhi_c[POS_W-1:0];
			empty_q <= (xlo_c > xhi_c) || (ylo_c > yhi_c);
			x_q     <= xlo_c[POS_W-1:0];
			y_q     <= ylo_c[POS_W-1:0];
		end else if (cmd.issue) begin
			if (x_q == xhi_q) begin
				x_q <= xlo_q;
				y_q <= y_q + 1'b1;
			end else begin
				x_q <= x_q + 1'b1;
			end
		end
		if (cmd.issue) begin
			x_s1 <= x_q;
			y_s1 <= y_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_s1 <= 1'b0;
			clr_q       <= '0;
		end else begin
			rd_valid_s1 <= cmd.issue;
			if (cmd.clear) begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	assign hit      = rd_valid_s1 && (mem_rdata == CODE_UNSCANNED);
	assign mark_hit = hit && (op_q == OP_MARK);

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = {y_s1, x_s1};
		mem_wdata = CODE_SCANNED;
		if (cmd.clear) begin
			mem_we    = 1'b1;
			mem_waddr = clr_q;
			mem_wdata = CODE_UNSCANNED;
		end else if (cmd.wr_tile) begin
			mem_we    = 1'b1;
			mem_waddr = {py_q, px_q};
			mem_wdata = code_q;
		end else if (mark_hit) begin
			mem_we = 1'b1;
		end
	end

	cgwm_ram #(
		.WIDTH (CODE_W),
		.DEPTH (DEPTH)
	) u_grid (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr ({y_q, x_q}),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found       <= 1'b0;
			tile_x      <= '1;
			tile_y      <= '1;
			all_scanned <= 1'b0;
		end else if (cmd.load) begin
			found       <= 1'b0;
			tile_x      <= '1;
			tile_y      <= '1;
			all_scanned <= 1'b0;
		end else if (cmd.set_found) begin
			found  <= 1'b1;
			tile_x <= $signed({1'b0, x_s1});
			tile_y <= $signed({1'b0, y_s1});
		end else if (cmd.set_all) begin
			all_scanned <= 1'b1;
		end
	end

	assign stat.op       = op_q;
	assign stat.clr_last = &clr_q;
	assign stat.empty    = empty_q;
	assign stat.last     = (x_q == xhi_q) && (y_q == yhi_q);
	assign stat.hit      = hit;

endmodule

// ===== src/coverage_grid_window_marker.sv =====
// Coverage grid window marker: a 4096-entry grid of tile codes with window marking and search.
// A window mark or a search visits up to 961 or 4096 tiles, one tile per cycle through
// the single grid memory read port. One command at a time.
// After reset, busy stays high while the grid is cleared one tile per cycle.
// Results hold until the next command; done is high for a single cycle and cannot be stalled.
module coverage_grid_window_marker
	import cgwm_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [1:0]                opcode,
	input  logic [POS_W-1:0]          pos_x,
	input  logic [POS_W-1:0]          pos_y,
	input  logic [CODE_W-1:0]         tile_code,
	input  logic                      cfg_we,
	input  logic [CIDX_W-1:0]         cfg_index,
	input  logic [CFG_W-1:0]          cfg_data,
	output logic                      done,
	output logic                      found,
	output logic signed [COORD_W-1:0] tile_x,
	output logic signed [COORD_W-1:0] tile_y,
	output logic                      all_scanned
);

	cgwm_cmd_t  cmd;
	cgwm_stat_t stat;

	cgwm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	cgwm_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.opcode      (opcode),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.tile_code   (tile_code),
		.cmd         (cmd),
		.stat        (stat),
		.found       (found),
		.tile_x      (tile_x),
		.tile_y      (tile_y),
		.all_scanned (all_scanned)
	);

endmodule

// ===== tb/coverage_grid_window_marker_test.sv =====
// Self-checking testbench for coverage_grid_window_marker: tile writes, window marks and
// first-unscanned searches, checked against a behavioral copy of the coverage grid.
// Depends on cgwm_pkg and the coverage_grid_window_marker RTL only.
module coverage_grid_window_marker_test;
	timeunit 1ns;
	timeprecision 1ps;
	import cgwm_pkg::*;

	localparam logic [1:0] OP_UNDEFINED = 2'd3;
	localparam int CYCLE_LIMIT = 3_000_000;
	localparam int RANDOM_ITEMS = 115;

	typedef struct packed {
		logic                      found;
		logic signed [COORD_W-1:0] tile_x;
		logic signed [COORD_W-1:0] tile_y;
		logic                      all_scanned;
	} grid_answer_t;

	logic                      clk;
	logic                      arst_n;
	logic                      start;
	logic                      busy;
	logic [1:0]                opcode;
	logic [POS_W-1:0]          pos_x;
	logic [POS_W-1:0]          pos_y;
	logic [CODE_W-1:0]         tile_code;
	logic                      cfg_we;
	logic [CIDX_W-1:0]         cfg_index;
	logic [CFG_W-1:0]          cfg_data;
	logic                      done;
	logic                      found;
	logic signed [COORD_W-1:0] tile_x;
	logic signed [COORD_W-1:0] tile_y;
	logic                      all_scanned;

	// Behavioral copy of the grid and the three settings.
	logic [CODE_W-1:0] grid_copy [DEPTH];
	int range_setting;
	int width_setting;
	int height_setting;

	grid_answer_t pending_answers [$];
	int mismatch_count;
	int idle_pct;
	int items_sent;
	int setting_writes;
	int full_grid_searches;
	int op_count [4];

	coverage_grid_window_marker u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.opcode     (opcode),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.tile_code  (tile_code),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.done       (done),
		.found      (found),
		.tile_x     (tile_x),
		.tile_y     (tile_y),
		.all_scanned(all_scanned)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Applies one command to the grid copy and returns the answer the block must give.
	function automatic grid_answer_t predict_grid_answer(input logic [1:0] op,
			input logic [POS_W-1:0] px, input logic [POS_W-1:0] py,
			input logic [CODE_W-1:0] code);
		grid_answer_t ans;
		int r;
		int w;
		int h;
		int x;
		int y;
		ans.found       = 1'b0;
		ans.tile_x      = '1;
		ans.tile_y      = '1;
		ans.all_scanned = 1'b0;
		r = (range_setting < MAX_RANGE) ? range_setting : MAX_RANGE;
		w = (width_setting < MAX_WIDTH) ? width_setting : MAX_WIDTH;
		h = (height_setting < MAX_HEIGHT) ? height_setting : MAX_HEIGHT;
		case (op)
			OP_WRITE: begin
				grid_copy[int'(py) * MAX_WIDTH + int'(px)] = code;
			end
			OP_MARK: begin
				// Row 0 and column 0 are never marked, nor anything past the grid in use.
				for (y = int'(py) - r; y <= int'(py) + r; y++) begin
					if (y >= 1 && y <= h - 1) begin
						for (x = int'(px) - r; x <= int'(px) + r; x++) begin
							if (x >= 1 && x <= w - 1 &&
									grid_copy[y * MAX_WIDTH + x] == CODE_UNSCANNED)
								grid_copy[y * MAX_WIDTH + x] = CODE_SCANNED;
						end
					end
				end
			end
			OP_FIND: begin
				ans.all_scanned = 1'b1;
				for (y = 0; y < h && !ans.found; y++) begin
					for (x = 0; x < w && !ans.found; x++) begin
						if (grid_copy[y * MAX_WIDTH + x] == CODE_UNSCANNED) begin
							ans.found       = 1'b1;
							ans.all_scanned = 1'b0;
							ans.tile_x      = COORD_W'(x);
							ans.tile_y      = COORD_W'(y);
						end
					end
				end
			end
			default: ;
		endcase
		return ans;
	endfunction

	// Sends one command beat, after a random hold-off, and records its expected answer.
	task automatic issue_command(input logic [1:0] op, input int px, input int py,
			input int code);
		grid_answer_t ans;
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start     <= 1'b1;
		opcode    <= op;
		pos_x     <= POS_W'(px);
		pos_y     <= POS_W'(py);
		tile_code <= CODE_W'(code);
		do @(posedge clk); while (busy !== 1'b0);
		ans = predict_grid_answer(opcode, pos_x, pos_y, tile_code);
		if (ans.all_scanned)
			full_grid_searches++;
		pending_answers.push_back(ans);
		op_count[opcode]++;
		items_sent++;
	endtask

	// Drops start and waits until every answer has arrived and the block is idle.
	task automatic wait_grid_idle();
		@(negedge clk);
		start <= 1'b0;
		while (pending_answers.size() != 0) @(posedge clk);
		do @(posedge clk); while (busy !== 1'b0);
	endtask

	task automatic write_setting(input logic [CIDX_W-1:0] idx, input int value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CFG_W'(value);
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_RANGE:  range_setting  = value & 'hF;
			CFG_WIDTH:  width_setting  = value & 'h7F;
			CFG_HEIGHT: height_setting = value & 'h7F;
			default: ;
		endcase
		setting_writes++;
	endtask

	// Fresh grid at reset settings: the corner tile is the first unscanned one.
	task automatic test_power_up_state();
		issue_command(OP_FIND, 63, 63, 255);
		issue_command(OP_WRITE, 0, 0, 8'hFF);
		issue_command(OP_FIND, 0, 0, 0);
		issue_command(OP_MARK, 0, 0, 0);
	endtask

	// A 4x3 grid filled by border writes and a wide window, then one tile reopened.
	task automatic test_small_grid_sweep();
		wait_grid_idle();
		write_setting(CFG_RANGE, 15);
		write_setting(CFG_WIDTH, 4);
		write_setting(CFG_HEIGHT, 3);
		issue_command(OP_WRITE, 1, 0, 8'h01);
		issue_command(OP_WRITE, 2, 0, 8'h80);
		issue_command(OP_WRITE, 3, 0, 8'h7E);
		issue_command(OP_WRITE, 0, 1, 8'h55);
		issue_command(OP_WRITE, 0, 2, 8'hAA);
		issue_command(OP_FIND, 0, 0, 0);
		issue_command(OP_MARK, 63, 63, 0);
		issue_command(OP_MARK, 5, 5, 0);
		issue_command(OP_FIND, 0, 0, 0);
		issue_command(OP_WRITE, 2, 2, 8'h00);
		issue_command(OP_FIND, 0, 0, 0);
	endtask

	// Empty grids of zero width or zero height, and sizes beyond storage that clamp to 64.
	task automatic test_size_limits();
		wait_grid_idle();
		write_setting(CFG_WIDTH, 0);
		issue_command(OP_FIND, 0, 0, 0);
		issue_command(OP_MARK, 1, 1, 0);
		wait_grid_idle();
		write_setting(CFG_WIDTH, 1);
		write_setting(CFG_HEIGHT, 0);
		issue_command(OP_FIND, 0, 0, 0);
		wait_grid_idle();
		write_setting(CFG_WIDTH, 127);
		write_setting(CFG_HEIGHT, 127);
		write_setting(CFG_RANGE, 0);
		issue_command(OP_MARK, 63, 63, 0);
		wait_grid_idle();
		write_setting(CFG_RANGE, 15);
		issue_command(OP_MARK, 63, 0, 0);
		issue_command(OP_FIND, 0, 0, 0);
	endtask

	// The unused opcode must leave the grid alone and give the default answer.
	task automatic test_undefined_opcode();
		issue_command(OP_UNDEFINED, 63, 63, 8'hFF);
		issue_command(OP_FIND, 0, 0, 0);
	endtask

	// Random runs: mostly border fill, marks and searches on small grids, some noise.
	task automatic test_random_coverage_runs();
		int first;
		int n;
		int w;
		int h;
		int wu;
		int hu;
		int i;
		first = items_sent;
		while (items_sent - first < RANDOM_ITEMS) begin
			n = items_sent - first;
			idle_pct = (n < RANDOM_ITEMS / 3) ? 16 : (n < 2 * RANDOM_ITEMS / 3) ? 69 : 0;
			wait_grid_idle();
			if ($urandom_range(5) == 0) begin
				w = $urandom_range(33, 127);
				h = $urandom_range(33, 127);
			end else begin
				w = $urandom_range(0, 9);
				h = $urandom_range(0, 9);
			end
			write_setting(CFG_RANGE, $urandom_range(15));
			write_setting(CFG_WIDTH, w);
			write_setting(CFG_HEIGHT, h);
			wu = (w < MAX_WIDTH) ? w : MAX_WIDTH;
			hu = (h < MAX_HEIGHT) ? h : MAX_HEIGHT;
			if ($urandom_range(3) != 0) begin
				// Row 0 and column 0 can only be covered by writes, so fill most of them.
				if (wu <= 10 && hu <= 10) begin
					for (i = 0; i < wu; i++)
						if ($urandom_range(6) != 0)
							issue_command(OP_WRITE, i, 0, $urandom_range(1, 255));
					for (i = 1; i < hu; i++)
						if ($urandom_range(6) != 0)
							issue_command(OP_WRITE, 0, i, $urandom_range(1, 255));
				end
				repeat ($urandom_range(1, 4))
					issue_command(OP_MARK, $urandom_range(0, (wu + 2 < 63) ? wu + 2 : 63),
						$urandom_range(0, (hu + 2 < 63) ? hu + 2 : 63), $urandom_range(255));
				issue_command(OP_FIND, $urandom_range(63), $urandom_range(63),
					$urandom_range(255));
				if ($urandom_range(1) != 0) begin
					issue_command(OP_WRITE, $urandom_range(0, (wu > 0) ? wu - 1 : 0),
						$urandom_range(0, (hu > 0) ? hu - 1 : 0),
						($urandom_range(1) != 0) ? 0 : $urandom_range(255));
					issue_command(OP_FIND, $urandom_range(63), $urandom_range(63),
						$urandom_range(255));
				end
			end else begin
				repeat ($urandom_range(4, 8))
					issue_command(2'($urandom_range(3)), $urandom_range(63),
						$urandom_range(63), $urandom_range(255));
			end
		end
	endtask

	// Every answer beat is compared with the oldest outstanding expectation.
	always @(posedge clk) begin
		grid_answer_t want;
		if (arst_n && done) begin
			if (pending_answers.size() == 0) begin
				$error("answer beat arrived with no command outstanding");
				mismatch_count++;
			end else begin
				want = pending_answers.pop_front();
				if (found !== want.found) begin
					$error("found: expected %0d, got %0d", want.found, found);
					mismatch_count++;
				end
				if (tile_x !== want.tile_x) begin
					$error("tile_x: expected %0d, got %0d", $signed(want.tile_x), tile_x);
					mismatch_count++;
				end
				if (tile_y !== want.tile_y) begin
					$error("tile_y: expected %0d, got %0d", $signed(want.tile_y), tile_y);
					mismatch_count++;
				end
				if (all_scanned !== want.all_scanned) begin
					$error("all_scanned: expected %0d, got %0d", want.all_scanned,
						all_scanned);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("coverage_grid_window_marker regression: fail");
		$finish;
	end

	initial begin
		arst_n             = 1'b0;
		start              = 1'b0;
		opcode             = OP_WRITE;
		pos_x              = '0;
		pos_y              = '0;
		tile_code          = '0;
		cfg_we             = 1'b0;
		cfg_index          = CFG_RANGE;
		cfg_data           = '0;
		foreach (grid_copy[i])
			grid_copy[i] = CODE_UNSCANNED;
		range_setting      = 2;
		width_setting      = 64;
		height_setting     = 64;
		mismatch_count     = 0;
		idle_pct           = 16;
		items_sent         = 0;
		setting_writes     = 0;
		full_grid_searches = 0;
		foreach (op_count[i])
			op_count[i] = 0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		test_power_up_state();
		test_small_grid_sweep();
		test_size_limits();
		test_undefined_opcode();
		test_random_coverage_runs();

		wait_grid_idle();
		repeat (20) @(posedge clk);
		$display("Sent %0d commands: %0d writes, %0d marks, %0d searches, %0d undefined.",
			items_sent, op_count[OP_WRITE], op_count[OP_MARK], op_count[OP_FIND],
			op_count[OP_UNDEFINED]);
		$display("%0d register writes over empty to clamped grids; %0d searches found none.",
			setting_writes, full_grid_searches);
		if (mismatch_count == 0)
			$display("coverage_grid_window_marker regression: pass");
		else
			$display("coverage_grid_window_marker regression: fail");
		$finish;
	end

endmodule
